### hw/rtl/udpcsc_pkg.sv
// Shared types and constants for the UDP header checksum check unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package udpcsc_pkg;

  // Fixed protocol constants.
  localparam logic [15:0] UDP_PROTO   = 16'd17;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;
  localparam logic [15:0] DNS_PORT    = 16'd53;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;

  // Widths of the running sums.
  localparam int unsigned ACC_W   = 17;  // data sum, end-around carry kept one bit wide
  localparam int unsigned PSUM_W  = 19;  // raw pseudo-header sum of five 16-bit words
  localparam int unsigned TOTAL_W = 20;  // data sum plus pseudo-header plus length

  localparam logic [ACC_W-1:0] SUM_ALL_ONES = 17'h0FFFF;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_CSUM_ERR = 2'd3
  } status_e;

  // One finished segment as it leaves the parser, before the checksum verdict.
  typedef struct packed {
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
    logic [15:0]      udp_len;
    status_e          pre_status;  // truncated or bad length, else ok
    logic             ck_zero;     // checksum field was zero: skip the check
    logic [ACC_W-1:0] acc;         // data sum, congruent modulo 0xFFFF
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/udpcsc_pseudo.sv
// Pseudo-header sum: holds the IPv4 addresses of the current segment and
// sums their halves with the protocol number. Depends on udpcsc_pkg.
`default_nettype none

module udpcsc_pseudo (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           capture_i,
  input  wire logic [31:0]                    src_addr_i,
  input  wire logic [31:0]                    dst_addr_i,
  output      logic [udpcsc_pkg::PSUM_W-1:0]  psum_o
);
  import udpcsc_pkg::*;

  logic [31:0]       src_addr_q;
  logic [31:0]       dst_addr_q;
  logic [PSUM_W-1:0] psum_d;
  logic [PSUM_W-1:0] psum_q;

  // Addresses are taken on the first item of a segment.
  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      src_addr_q <= src_addr_i;
      dst_addr_q <= dst_addr_i;
    end
  end

  // Five-word sum, registered behind the captured addresses; it settles
  // long before a full header has arrived.
  assign psum_d = PSUM_W'(src_addr_q[31:16]) + PSUM_W'(src_addr_q[15:0])
                + PSUM_W'(dst_addr_q[31:16]) + PSUM_W'(dst_addr_q[15:0])
                + PSUM_W'(UDP_PROTO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_q <= '0;
    end else begin
      psum_q <= psum_d;
    end
  end

  assign psum_o = psum_q;

endmodule

`default_nettype wire

### hw/rtl/udpcsc_parse.sv
// Per-byte parser: byte position, header capture, running data sum and
// the early status checks. Depends on udpcsc_pkg.
`default_nettype none

module udpcsc_parse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  output      logic              first_o,
  output      udpcsc_pkg::res_t  res_o
);
  import udpcsc_pkg::*;

  logic [15:0]      pos_q, pos_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [15:0]      src_q, src_d;
  logic [15:0]      dst_q, dst_d;
  logic [15:0]      len_q, len_d;
  logic [15:0]      ck_q, ck_d;

  logic             first;
  logic             summed;
  logic [15:0]      word;
  logic [ACC_W-1:0] acc_base;
  logic [ACC_W-1:0] acc_add;
  status_e          pre_status;

  assign first = (pos_q == '0);

  // Header capture; a new segment clears the fields it has not reached yet.
  always_comb begin
    src_d = first ? '0 : src_q;
    dst_d = first ? '0 : dst_q;
    len_d = first ? '0 : len_q;
    ck_d  = first ? '0 : ck_q;
    unique case (pos_q)
      16'd0:   src_d = {data_byte_i, 8'h00};
      16'd1:   src_d = {src_q[15:8], data_byte_i};
      16'd2:   dst_d = {data_byte_i, 8'h00};
      16'd3:   dst_d = {dst_q[15:8], data_byte_i};
      16'd4:   len_d = {data_byte_i, 8'h00};
      16'd5:   len_d = {len_q[15:8], data_byte_i};
      16'd6:   ck_d  = {data_byte_i, 8'h00};
      16'd7:   ck_d  = {ck_q[15:8], data_byte_i};
      default: ;
    endcase
  end

  // Running sum over header and the first udp_len bytes. The carry out of
  // bit 15 is fed back on the next add, so the sum stays 17 bits wide.
  assign summed   = (pos_q < 16'd6) || (pos_q < len_q);
  assign word     = pos_q[0] ? {8'h00, data_byte_i} : {data_byte_i, 8'h00};
  assign acc_base = first ? '0 : acc_q;
  assign acc_add  = ACC_W'(acc_base[15:0]) + ACC_W'(acc_base[ACC_W-1]) + ACC_W'(word);
  assign acc_d    = summed ? acc_add : acc_base;

  // Position saturates; a last item starts the next segment.
  always_comb begin
    if (last_byte_i) begin
      pos_d = '0;
    end else if (pos_q != POS_MAX) begin
      pos_d = pos_q + 16'd1;
    end else begin
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
      src_q <= '0;
      dst_q <= '0;
      len_q <= '0;
      ck_q  <= '0;
    end else if (fire_i) begin
      pos_q <= pos_d;
      acc_q <= last_byte_i ? '0 : acc_d;
      src_q <= src_d;
      dst_q <= dst_d;
      len_q <= len_d;
      ck_q  <= ck_d;
    end
  end

  // Checks that do not need the final sum.
  always_comb begin
    if (pos_q < 16'd7) begin
      pre_status = ST_TRUNC;
    end else if ((len_d < UDP_HDR_LEN) || ({1'b0, len_d} > ({1'b0, pos_q} + 17'd1))) begin
      pre_status = ST_BAD_LEN;
    end else begin
      pre_status = ST_OK;
    end
  end

  assign first_o          = first;
  assign res_o.src_port   = src_d;
  assign res_o.dst_port   = dst_d;
  assign res_o.udp_len    = len_d;
  assign res_o.pre_status = pre_status;
  assign res_o.ck_zero    = (ck_d == '0);
  assign res_o.acc        = acc_d;

  // A last item always leaves the parser at the start of a segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_byte_i |=> pos_q == '0)
    else $error("position not cleared after a last item");

  // The position holds at its ceiling instead of wrapping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !last_byte_i && pos_q == POS_MAX |=> pos_q == POS_MAX)
    else $error("byte position wrapped");

endmodule

`default_nettype wire

### hw/rtl/udpcsc_verdict.sv
// Result stage and output register: adds the pseudo-header and length to
// the data sum and settles the final status. Depends on udpcsc_pkg.
`default_nettype none

module udpcsc_verdict (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           res_valid_i,
  input  wire udpcsc_pkg::res_t               res_i,
  input  wire logic [udpcsc_pkg::PSUM_W-1:0]  psum_i,
  output      logic                           res_ready_o,
  output      logic                           valid_o,
  input  wire logic                           stall_i,
  output      logic [15:0]                    src_port_o,
  output      logic [15:0]                    dst_port_o,
  output      logic [15:0]                    udp_len_o,
  output      logic [1:0]                     status_o,
  output      logic                           is_dns_o
);
  import udpcsc_pkg::*;

  logic              b_valid_q;
  res_t              b_res_q;
  logic [PSUM_W-1:0] b_psum_q;

  logic              out_valid_q;
  logic [15:0]       src_port_q;
  logic [15:0]       dst_port_q;
  logic [15:0]       udp_len_q;
  status_e           status_q;
  logic              is_dns_q;

  logic              out_ready;
  logic [TOTAL_W-1:0] total;
  logic [ACC_W-1:0]   fold;
  logic               sum_ok;
  status_e            status_d;

  assign out_ready   = !out_valid_q || !stall_i;
  assign res_ready_o = !b_valid_q || out_ready;

  // Result stage: one finished segment waiting for the sum check.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (res_valid_i) begin
      b_valid_q <= 1'b1;
    end else if (out_ready) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      b_res_q  <= res_i;
      b_psum_q <= psum_i;
    end
  end

  // The sum is ok when the total is a nonzero multiple of 0xFFFF; the
  // protocol word keeps the total nonzero, so one fold decides it.
  assign total  = TOTAL_W'(b_res_q.acc) + TOTAL_W'(b_psum_q) + TOTAL_W'(b_res_q.udp_len);
  assign fold   = ACC_W'(total[15:0]) + ACC_W'(total[TOTAL_W-1:16]);
  assign sum_ok = (fold == SUM_ALL_ONES);

  always_comb begin
    if (b_res_q.pre_status != ST_OK) begin
      status_d = b_res_q.pre_status;
    end else if (!b_res_q.ck_zero && !sum_ok) begin
      status_d = ST_CSUM_ERR;
    end else begin
      status_d = ST_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && b_valid_q) begin
      src_port_q <= b_res_q.src_port;
      dst_port_q <= b_res_q.dst_port;
      udp_len_q  <= b_res_q.udp_len;
      status_q   <= status_d;
      is_dns_q   <= (status_d == ST_OK) && (b_res_q.dst_port == DNS_PORT);
    end
  end

  assign valid_o    = out_valid_q;
  assign src_port_o = src_port_q;
  assign dst_port_o = dst_port_q;
  assign udp_len_o  = udp_len_q;
  assign status_o   = status_q;
  assign is_dns_o   = is_dns_q;

  // The result stage is never written while it still holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> res_ready_o)
    else $error("result stage overwritten");

  // A DNS mark only goes with a clean result to port 53.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_dns_o |-> status_o == ST_OK && dst_port_o == DNS_PORT)
    else $error("DNS mark on a bad or foreign result");

endmodule

`default_nettype wire

### hw/rtl/udp_header_checksum_check_unit.sv
// Top level of the UDP header checksum check unit: input register and
// handshake, with udpcsc_parse, udpcsc_pseudo and udpcsc_verdict below.
// Depends on udpcsc_pkg.
//
//   Channel  Direction  Handshake          Fields
//   in       sink       valid_i, stall_o   data_byte_i, last_byte_i, src_addr_i, dst_addr_i
//   out      source     valid_o, stall_i   src_port_o, dst_port_o, udp_len_o, status_o, is_dns_o
//
// One byte is taken per cycle unless stall_o holds a last byte back. A result
// passes through the input register, result stage and output register.
// Reset clears all valid flags, the byte position and the running sum.
// A stall on the output fills the result stage, then holds a last byte in
// the input register; bytes that are not last keep flowing meanwhile.
`default_nettype none

module udp_header_checksum_check_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output      logic        stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [31:0] dst_addr_i,
  output      logic        valid_o,
  input  wire logic        stall_i,
  output      logic [15:0] src_port_o,
  output      logic [15:0] dst_port_o,
  output      logic [15:0] udp_len_o,
  output      logic [1:0]  status_o,
  output      logic        is_dns_o
);
  import udpcsc_pkg::*;

  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              last_q;
  logic [31:0]       src_addr_q;
  logic [31:0]       dst_addr_q;

  logic              in_free;
  logic              fire;
  logic              res_ready;
  logic              first;
  res_t              res;
  logic [PSUM_W-1:0] psum;

  // A byte leaves the input register at once, unless it ends a segment and
  // the result stage is still occupied.
  assign fire    = in_valid_q && (!last_q || res_ready);
  assign in_free = !in_valid_q || fire;
  assign stall_o = !in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_free) begin
      in_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && valid_i) begin
      byte_q     <= data_byte_i;
      last_q     <= last_byte_i;
      src_addr_q <= src_addr_i;
      dst_addr_q <= dst_addr_i;
    end
  end

  udpcsc_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .first_o     (first),
    .res_o       (res)
  );

  udpcsc_pseudo u_pseudo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .capture_i  (fire && first),
    .src_addr_i (src_addr_q),
    .dst_addr_i (dst_addr_q),
    .psum_o     (psum)
  );

  udpcsc_verdict u_verdict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (fire && last_q),
    .res_i       (res),
    .psum_i      (psum),
    .res_ready_o (res_ready),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .src_port_o  (src_port_o),
    .dst_port_o  (dst_port_o),
    .udp_len_o   (udp_len_o),
    .status_o    (status_o),
    .is_dns_o    (is_dns_o)
  );

  // Only a last byte can ever be held back in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !last_q |-> !stall_o)
    else $error("byte that is not last was held");

  // A held item was refused because the result stage was full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> in_valid_q && last_q && !res_ready)
    else $error("input stalled without cause");

endmodule

`default_nettype wire

### dv/udp_header_checksum_check_unit_tb.sv
// Self-checking testbench for the UDP header checksum check unit.
// Drives whole UDP segments byte by byte and compares every result with a
// cycle-free predictor held in a small scoreboard class; needs udpcsc_pkg.
`default_nettype none

module udp_header_checksum_check_unit_tb;
  import udpcsc_pkg::*;

  localparam int unsigned RANDOM_BYTES   = 1500;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT = 400;

  // One finished segment as seen on the output port.
  typedef struct packed {
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] udp_len;
    status_e     status;
    logic        is_dns;
  } seg_result_t;

  // Shapes of generated segments.
  typedef enum int unsigned {
    SEG_GOOD,
    SEG_BAD_SUM,
    SEG_ZERO_SUM,
    SEG_SHORT_LEN,
    SEG_LONG_LEN,
    SEG_TRUNC
  } seg_kind_e;

  // Predicts segment verdicts byte by byte and matches them against the port.
  class udp_result_board;
    logic [15:0] seg_pos;
    logic [16:0] run_sum;
    logic [15:0] cap_sport;
    logic [15:0] cap_dport;
    logic [15:0] cap_len;
    logic [15:0] cap_csum;
    seg_result_t verdict_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned by_status[4];
    int unsigned dns_hits;

    function new();
      seg_pos   = '0;
      run_sum   = '0;
      cap_sport = '0;
      cap_dport = '0;
      cap_len   = '0;
      cap_csum  = '0;
      mismatches = 0;
      checked    = 0;
      dns_hits   = 0;
      foreach (by_status[i]) by_status[i] = 0;
    endfunction

    // Ones' complement add with end-around carry.
    function logic [16:0] fold_add(logic [16:0] s, logic [15:0] v);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + {1'b0, v};
      return {1'b0, t[15:0]} + {16'h0000, t[16]};
    endfunction

    // Advances the predictor by one accepted byte; queues a verdict on a last byte.
    function void note_byte(logic [7:0] b, logic last, logic [31:0] sa, logic [31:0] da);
      logic [15:0] p;
      logic [16:0] count;
      status_e     st;
      seg_result_t r;
      p = seg_pos;
      if (p == 16'd0) begin
        cap_sport = '0;
        cap_dport = '0;
        cap_len   = '0;
        cap_csum  = '0;
        run_sum   = '0;
        run_sum   = fold_add(run_sum, sa[31:16]);
        run_sum   = fold_add(run_sum, sa[15:0]);
        run_sum   = fold_add(run_sum, da[31:16]);
        run_sum   = fold_add(run_sum, da[15:0]);
        run_sum   = fold_add(run_sum, UDP_PROTO);
      end
      case (p)
        16'd0: cap_sport = {b, 8'h00};
        16'd1: cap_sport = cap_sport | {8'h00, b};
        16'd2: cap_dport = {b, 8'h00};
        16'd3: cap_dport = cap_dport | {8'h00, b};
        16'd4: cap_len   = {b, 8'h00};
        16'd5: cap_len   = cap_len | {8'h00, b};
        16'd6: cap_csum  = {b, 8'h00};
        16'd7: cap_csum  = cap_csum | {8'h00, b};
        default: ;
      endcase
      // The length enters the pseudo-header once it is complete.
      if (p == 16'd5) run_sum = fold_add(run_sum, cap_len);
      if (p < 16'd6 || p < cap_len) begin
        run_sum = fold_add(run_sum, p[0] ? {8'h00, b} : {b, 8'h00});
      end
      if (last) begin
        count = {1'b0, p} + 17'd1;
        if (count < {1'b0, UDP_HDR_LEN}) st = ST_TRUNC;
        else if (cap_len < UDP_HDR_LEN || {1'b0, cap_len} > count) st = ST_BAD_LEN;
        else if (cap_csum != 16'h0000 && run_sum != SUM_ALL_ONES) st = ST_CSUM_ERR;
        else st = ST_OK;
        r.src_port = cap_sport;
        r.dst_port = cap_dport;
        r.udp_len  = cap_len;
        r.status   = st;
        r.is_dns   = (st == ST_OK) && (cap_dport == DNS_PORT);
        verdict_q.push_back(r);
        seg_pos = '0;
        run_sum = '0;
      end else if (p != POS_MAX) begin
        seg_pos = p + 16'd1;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compares one result from the port with the oldest pending verdict.
    task check_result(seg_result_t got);
      seg_result_t want;
      if (verdict_q.size() == 0) begin
        report($sformatf("result with no segment pending: %p", got));
        return;
      end
      want = verdict_q.pop_front();
      checked++;
      by_status[want.status]++;
      if (want.is_dns) dns_hits++;
      if (got.src_port !== want.src_port)
        report($sformatf("src_port %h, predicted %h", got.src_port, want.src_port));
      if (got.dst_port !== want.dst_port)
        report($sformatf("dst_port %h, predicted %h", got.dst_port, want.dst_port));
      if (got.udp_len !== want.udp_len)
        report($sformatf("udp_len %h, predicted %h", got.udp_len, want.udp_len));
      if (got.status !== want.status)
        report($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.is_dns !== want.is_dns)
        report($sformatf("is_dns %b, predicted %b", got.is_dns, want.is_dns));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic [31:0] src_addr_i;
  logic [31:0] dst_addr_i;
  logic        valid_o;
  logic        stall_i;
  logic [15:0] src_port_o;
  logic [15:0] dst_port_o;
  logic [15:0] udp_len_o;
  logic [1:0]  status_o;
  logic        is_dns_o;

  udp_result_board sb = new();
  logic [7:0]  seg_bytes[$];
  logic        tx_idle_on;
  logic        rx_idle_on;
  int unsigned idle_cycles;
  int unsigned segs_sent;
  int unsigned bytes_sent;

  udp_header_checksum_check_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .src_addr_i  (src_addr_i),
    .dst_addr_i  (dst_addr_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .src_port_o  (src_port_o),
    .dst_port_o  (dst_port_o),
    .udp_len_o   (udp_len_o),
    .status_o    (status_o),
    .is_dns_o    (is_dns_o)
  );

  // Clock and a single reset pulse at the start.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Monitor: feeds the scoreboard on both handshakes and watches for a hang.
  always @(posedge clk_i) begin
    seg_result_t got;
    if (rst_ni) begin
      if (valid_i && !stall_o) sb.note_byte(data_byte_i, last_byte_i, src_addr_i, dst_addr_i);
      if (valid_o && !stall_i) begin
        got.src_port = src_port_o;
        got.dst_port = dst_port_o;
        got.udp_len  = udp_len_o;
        got.status   = status_e'(status_o);
        got.is_dns   = is_dns_o;
        sb.check_result(got);
      end
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: holds off each result for a random number of cycles.
  initial begin
    int unsigned hold;
    stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      hold = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (hold != 0) begin
        stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!valid_o);
      @(negedge clk_i);
    end
  end

  // Ones' complement sum of the pseudo-header and the first len bytes.
  function automatic logic [15:0] segment_sum(logic [31:0] sa, logic [31:0] da,
                                              int unsigned len);
    logic [31:0] acc;
    acc = sa[31:16] + sa[15:0] + da[31:16] + da[15:0] + UDP_PROTO + len;
    for (int unsigned i = 0; i < len; i += 2) begin
      acc += {seg_bytes[i], (i + 1 < len) ? seg_bytes[i + 1] : 8'h00};
    end
    while (acc[31:16] != 16'h0000) acc = acc[15:0] + acc[31:16];
    return acc[15:0];
  endfunction

  // Builds one segment into seg_bytes.
  task automatic make_segment(seg_kind_e kind, int unsigned payload, int unsigned extra,
                              int unsigned cut, logic [15:0] dport,
                              logic [31:0] sa, logic [31:0] da);
    int unsigned total;
    int unsigned idx;
    logic [15:0] len_field;
    logic [15:0] sport;
    logic [15:0] csum;
    seg_bytes.delete();
    sport = 16'($urandom);
    total = 8 + payload + extra;
    case (kind)
      SEG_SHORT_LEN: len_field = 16'($urandom_range(0, 7));
      SEG_LONG_LEN:  len_field = 16'(total + $urandom_range(1, 8));
      default:       len_field = 16'(8 + payload);
    endcase
    seg_bytes.push_back(sport[15:8]);
    seg_bytes.push_back(sport[7:0]);
    seg_bytes.push_back(dport[15:8]);
    seg_bytes.push_back(dport[7:0]);
    seg_bytes.push_back(len_field[15:8]);
    seg_bytes.push_back(len_field[7:0]);
    seg_bytes.push_back(8'h00);
    seg_bytes.push_back(8'h00);
    repeat (payload + extra) seg_bytes.push_back(8'($urandom));
    case (kind)
      SEG_GOOD, SEG_BAD_SUM: begin
        csum = ~segment_sum(sa, da, len_field);
        if (csum == 16'h0000) csum = 16'hFFFF;
        seg_bytes[6] = csum[15:8];
        seg_bytes[7] = csum[7:0];
        // Corrupt one summed byte outside the length field.
        if (kind == SEG_BAD_SUM) begin
          if (payload != 0 && $urandom_range(0, 1)) idx = 8 + $urandom_range(0, payload - 1);
          else idx = $urandom_range(0, 3);
          seg_bytes[idx] ^= 8'($urandom_range(1, 255));
        end
      end
      SEG_ZERO_SUM: ;
      default: begin
        seg_bytes[6] = 8'($urandom);
        seg_bytes[7] = 8'($urandom);
      end
    endcase
    if (kind == SEG_TRUNC) begin
      while (seg_bytes.size() > cut) void'(seg_bytes.pop_back());
    end
  endtask

  // Offers one byte after a random gap and waits for it to be taken.
  task automatic send_byte(logic [7:0] b, logic last, logic [31:0] sa, logic [31:0] da);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i     <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    src_addr_i  <= sa;
    dst_addr_i  <= da;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sends seg_bytes; addresses on later bytes are noise the block must ignore.
  task automatic send_segment(logic [31:0] sa, logic [31:0] da);
    int unsigned n;
    n = seg_bytes.size();
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(seg_bytes[i], i == n - 1, (i == 0) ? sa : $urandom, (i == 0) ? da : $urandom);
    end
    segs_sent++;
    bytes_sent += n;
  endtask

  // Holds the input idle until every pending verdict has been seen.
  task automatic drain_results();
    valid_i <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Stimulus: directed corner segments, then random segments.
  initial begin
    seg_kind_e   kind;
    int unsigned r;
    int unsigned payload;
    int unsigned extra;
    logic [15:0] dport;
    logic        paused;
    logic [31:0] sa;
    logic [31:0] da;
    valid_i     = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    src_addr_i  = '0;
    dst_addr_i  = '0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    idle_cycles = 0;
    segs_sent   = 0;
    bytes_sent  = 0;
    paused      = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);

    // A single-byte segment, then seven zero bytes: both too short for a header.
    make_segment(SEG_TRUNC, 0, 0, 1, 16'($urandom), 32'h0, 32'hFFFF_FFFF);
    seg_bytes[0] = 8'hFF;
    send_segment(32'h0, 32'hFFFF_FFFF);
    make_segment(SEG_TRUNC, 0, 0, 7, 16'h0000, 32'hFFFF_FFFF, 32'h0);
    foreach (seg_bytes[i]) seg_bytes[i] = 8'h00;
    send_segment(32'hFFFF_FFFF, 32'h0);
    // A header-only DNS segment with a valid checksum, then a length below the header.
    make_segment(SEG_GOOD, 0, 0, 0, DNS_PORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    make_segment(SEG_SHORT_LEN, 0, 0, 0, 16'($urandom), 32'h0, 32'h0);
    send_segment(32'h0, 32'h0);
    drain_results();

    // Random segments, mostly well formed.
    while (bytes_sent < RANDOM_BYTES + 24) begin
      r = $urandom_range(0, 99);
      if (r < 50)      kind = SEG_GOOD;
      else if (r < 62) kind = SEG_BAD_SUM;
      else if (r < 72) kind = SEG_ZERO_SUM;
      else if (r < 80) kind = SEG_SHORT_LEN;
      else if (r < 88) kind = SEG_LONG_LEN;
      else             kind = SEG_TRUNC;
      payload = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
      extra   = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4);
      dport   = ($urandom_range(0, 4) == 0) ? DNS_PORT : 16'($urandom);
      sa      = pick_addr();
      da      = pick_addr();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      make_segment(kind, payload, extra, $urandom_range(1, 7), dport, sa, da);
      send_segment(sa, da);
      if (!paused && bytes_sent > RANDOM_BYTES / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
    drain_results();

    $display("Sent %0d segments in %0d bytes, with random gaps and output stalls.",
             segs_sent, bytes_sent);
    $display("Verdicts: %0d ok (%0d dns), %0d truncated, %0d bad length, %0d checksum errors.",
             sb.by_status[ST_OK], sb.dns_hits, sb.by_status[ST_TRUNC],
             sb.by_status[ST_BAD_LEN], sb.by_status[ST_CSUM_ERR]);
    if (sb.mismatches == 0 && sb.verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
